@@ rtl/cps_pkg.sv @@
`default_nettype none

package cps_pkg;

   localparam int STORE_DEPTH_DEF = 64;
   // position fields are sized for the deepest store allowed (4096)
   localparam int POS_W           = 12;
   localparam int CAP_W           = 7;
   localparam int IDX_W           = 6;
   localparam int START_W         = CAP_W + IDX_W;
   localparam logic [CAP_W-1:0] CAP_MIN   = 7'd1;
   localparam logic [CAP_W-1:0] CAP_MAX   = 7'd64;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd3;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_POP_AT = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_BAD_INDEX = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_PUSH   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_SCALE = 2'd1,
      S_PLAN  = 2'd2,
      S_APPLY = 2'd3
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] push_value;
      logic [IDX_W-1:0]   stack_index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      status_type         status;
      logic               now_empty;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      op_type           op;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] hi;
   } bc_type;

endpackage

`default_nettype wire

@@ rtl/cps_cell.sv @@
`default_nettype none

module cps_cell #(
   parameter int CELL_IDX = 0
) (
   input  wire                       clock,
   input  wire                       fire,
   input  cps_pkg::bc_type           bc,
   input  wire logic signed [31:0]   push_value,
   input  wire logic signed [31:0]   next_value,
   output logic signed [31:0]        value,
   output logic signed [31:0]        sel_value
);

   localparam logic [cps_pkg::POS_W-1:0] MY_IDX = cps_pkg::POS_W'(CELL_IDX);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               load;
   logic               shift;

   assign load  = fire && (bc.op == cps_pkg::OP_PUSH) && (bc.pos == MY_IDX);
   // the removed cell and the cells above it, below hi, take their upper neighbour's value
   assign shift = fire && (bc.op == cps_pkg::OP_REMOVE) && (bc.pos <= MY_IDX)
                  && (MY_IDX < bc.hi);

   always_comb begin
      priority if (load) begin
         value_in = push_value;
      end else if (shift) begin
         value_in = next_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign sel_value = (bc.pos == MY_IDX) ? value_ff : 32'sd0;

endmodule

`default_nettype wire

@@ rtl/capacity_partitioned_stack_unit.sv @@
// channel  | direction | handshake          | payload
// req_     | in        | req_valid/req_stall | cps_pkg::req_type
// rsp_     | out       | rsp_valid/rsp_stall | cps_pkg::rsp_type
// csr_     | in        | csr_valid/csr_ready | sub-stack capacity, 7 bits
//
// From transfer to result: start multiply, position plan, then one
// update of the cell row that shifts every later element down at once.
// The update waits while a stalled result holds the output register; the next
// command is taken the cycle after the update, so commands never overlap.
// Synchronous reset empties the store (count to zero) and sets capacity 3;
// cell contents are not cleared.
`default_nettype none

module capacity_partitioned_stack_unit #(
   parameter int STORE_DEPTH = cps_pkg::STORE_DEPTH_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  cps_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output cps_pkg::rsp_type                  rsp_data,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire logic [cps_pkg::CAP_W-1:0]    csr_data
);

   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W = ((CNT_W > cps_pkg::START_W) ? CNT_W : cps_pkg::START_W) + 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

   cps_pkg::state_type              state_ff, state_in;
   cps_pkg::req_type                req_ff;
   logic [cps_pkg::START_W-1:0]     start_ff, start_in;
   cps_pkg::bc_type                 bc_ff, bc_in;
   cps_pkg::status_type             status_ff, status_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [cps_pkg::CAP_W-1:0]       cap_ff;
   logic [cps_pkg::CAP_W-1:0]       cap_eff;
   logic                            rsp_valid_ff;
   cps_pkg::rsp_type                rsp_ff, rsp_in;
   logic                            accept;
   logic                            apply_fire;
   logic                            out_busy;

   logic signed [31:0] cell_value [STORE_DEPTH];
   logic signed [31:0] cell_sel   [STORE_DEPTH];
   logic signed [31:0] picked;

   logic [CMP_W-1:0] sum_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] end_min;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= cps_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   always_comb begin
      priority if (cap_ff < cps_pkg::CAP_MIN) begin
         cap_eff = cps_pkg::CAP_MIN;
      end else if (cap_ff > cps_pkg::CAP_MAX) begin
         cap_eff = cps_pkg::CAP_MAX;
      end else begin
         cap_eff = cap_ff;
      end
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cps_pkg::S_IDLE: begin
            if (accept) state_in = cps_pkg::S_SCALE;
         end
         cps_pkg::S_SCALE: begin
            state_in = cps_pkg::S_PLAN;
         end
         cps_pkg::S_PLAN: begin
            state_in = cps_pkg::S_APPLY;
         end
         cps_pkg::S_APPLY: begin
            if (!out_busy) state_in = cps_pkg::S_IDLE;
         end
         default: begin
            state_in = cps_pkg::S_IDLE;
         end
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_stall  = 1'b1;
      apply_fire = 1'b0;
      unique case (state_ff)
         cps_pkg::S_IDLE: begin
            req_stall = 1'b0;
         end
         cps_pkg::S_APPLY: begin
            apply_fire = !out_busy;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cps_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   assign start_in = cps_pkg::START_W'(req_ff.stack_index) * cps_pkg::START_W'(cap_eff);

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

   // top of the chosen sub-stack: min(start + cap, count) - 1
   assign sum_ext = CMP_W'(start_ff) + CMP_W'(cap_eff);
   assign cnt_ext = CMP_W'(count_ff);
   assign end_min = (sum_ext > cnt_ext) ? cnt_ext : sum_ext;

   always_comb begin
      bc_in.op  = cps_pkg::OP_NONE;
      bc_in.pos = cps_pkg::POS_W'(count_ff);
      bc_in.hi  = cps_pkg::POS_W'(count_ff - CNT_W'(1));
      status_in = cps_pkg::ST_OK;
      unique case (req_ff.cmd)
         cps_pkg::CMD_PUSH: begin
            if (count_ff == DEPTH_CNT) begin
               status_in = cps_pkg::ST_FULL;
            end else begin
               bc_in.op = cps_pkg::OP_PUSH;
            end
         end
         cps_pkg::CMD_POP: begin
            if (count_ff == '0) begin
               status_in = cps_pkg::ST_EMPTY;
            end else begin
               bc_in.op  = cps_pkg::OP_REMOVE;
               bc_in.pos = cps_pkg::POS_W'(count_ff - CNT_W'(1));
            end
         end
         cps_pkg::CMD_POP_AT: begin
            if (CMP_W'(start_ff) >= cnt_ext) begin
               status_in = cps_pkg::ST_BAD_INDEX;
            end else begin
               bc_in.op  = cps_pkg::OP_REMOVE;
               bc_in.pos = cps_pkg::POS_W'(end_min - CMP_W'(1));
            end
         end
         cps_pkg::CMD_NOP: begin
            bc_in.op = cps_pkg::OP_NONE;
         end
         default: begin
            bc_in.op = cps_pkg::OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == cps_pkg::S_PLAN) begin
         bc_ff     <= bc_in;
         status_ff <= status_in;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
         logic signed [31:0] upper;
         if (gi == STORE_DEPTH - 1) begin : g_top
            assign upper = 32'sd0;
         end else begin : g_mid
            assign upper = cell_value[gi+1];
         end
         cps_cell #(
            .CELL_IDX(gi)
         ) u_cell (
            .clock      (clock),
            .fire       (apply_fire),
            .bc         (bc_ff),
            .push_value (req_ff.push_value),
            .next_value (upper),
            .value      (cell_value[gi]),
            .sel_value  (cell_sel[gi])
         );
      end
   endgenerate

   // only the addressed cell drives a non-zero value
   always_comb begin
      picked = 32'sd0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         picked = picked | cell_sel[i];
      end
   end

   always_comb begin
      unique case (bc_ff.op)
         cps_pkg::OP_PUSH:   count_in = count_ff + CNT_W'(1);
         cps_pkg::OP_REMOVE: count_in = count_ff - CNT_W'(1);
         default:            count_in = count_ff;
      endcase
      rsp_in.popped_value = (bc_ff.op == cps_pkg::OP_REMOVE) ? picked : 32'sd0;
      rsp_in.status       = status_ff;
      rsp_in.now_empty    = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (apply_fire) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (apply_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/cps_checker.sv @@
`default_nettype none

module cps_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_valid,
   input wire                            rsp_stall,
   input cps_pkg::rsp_type               rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // failed commands return a zero popped value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != cps_pkg::ST_OK) |-> rsp_data.popped_value == 32'sd0)
      else $error("non-zero value on an error result");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == cps_pkg::ST_EMPTY) |-> rsp_data.now_empty)
      else $error("empty status without empty flag");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == cps_pkg::ST_FULL) |-> !rsp_data.now_empty)
      else $error("full status with empty flag");

endmodule

bind capacity_partitioned_stack_unit cps_checker u_cps_checker (.*);

`default_nettype wire
